// ----- rtl/core/polar_panorama_unwarp_defines.svh -----
// Assertion macros shared by the polar panorama unwarp RTL.
`ifndef POLAR_PANORAMA_UNWARP_DEFINES_SVH
`define POLAR_PANORAMA_UNWARP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock outside reset.
`define PPU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("polar_panorama_unwarp: check failed");
// Check that a condition is followed by another in the next cycle.
`define PPU_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("polar_panorama_unwarp: check failed");
`else
`define PPU_ASSERT(label, prop)
`define PPU_ASSERT_NEXT(label, cause, effect)
`endif

`endif

// ----- rtl/core/ppu_pkg.sv -----
// Shared types, codes, the sine entry function and index clamp helpers for the panorama unwarp.
`timescale 1ns / 1ps

package ppu_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_INNER_RADIUS = 3'd4,
        CFG_OUTER_RADIUS = 3'd5,
        CFG_PANO_WIDTH   = 3'd6,
        CFG_PHASE_STEP   = 3'd7
    } cfg_reg_t;

    // Control bits that travel with each request.
    typedef struct packed {
        logic valid;
        logic sample;
        logic bad;
    } ctl_t;

    // Pixel write payload.
    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [23:0] rgb;
    } wr_t;

    // Quarter turn in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    // Taylor term divisors (2n)(2n+1).
    localparam logic [63:0] TERM_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

    // Q16 sine of k quarter steps, from a Q30 Taylor sum.
    function automatic logic [16:0] sine_entry(input int unsigned k,
                                               input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x   = (64'(k) * HALF_PI_Q30) >> qbits;
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed(x);
        for (int n = 1; n <= 7; n++)
        begin
            t = ((t * x2) >> 30) / TERM_DIV[n - 1];
            if (n[0])
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        if (sum < 0)
            sum = '0;
        v = ($unsigned(sum) + 64'd8192) >> 14;
        return (v > 64'd65536) ? 17'd65536 : 17'(v);
    endfunction

    // Clamp a signed index into 0 .. lim-1.
    function automatic logic [15:0] clamp_idx(input logic signed [15:0] v,
                                              input logic [15:0] lim);
        logic signed [16:0] ls;
        ls = $signed({1'b0, lim});
        if (v < 0)
            return '0;
        else if ($signed({v[15], v}) >= ls)
            return lim - 16'd1;
        else
            return 16'(v);
    endfunction

    // True when a signed index falls outside 0 .. lim-1.
    function automatic logic out_of(input logic signed [15:0] v,
                                    input logic [15:0] lim);
        logic signed [16:0] ls;
        ls = $signed({1'b0, lim});
        return (v < 0) || ($signed({v[15], v}) >= ls);
    endfunction

endpackage

// ----- rtl/core/ppu_angle.sv -----
// Phase, radius and quarter-wave sine lookup stages.
`timescale 1ns / 1ps

module ppu_angle #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ppu_pkg::ctl_t       ctl_in,
    input  logic [11:0]         col,
    input  logic [8:0]          row,
    input  logic [8:0]          inner_radius,
    input  logic [9:0]          outer_radius,
    input  logic [11:0]         pano_width,
    input  logic [31:0]         phase_step,
    output ppu_pkg::ctl_t       ctl_out,
    output logic [16:0]         mag_s,
    output logic [16:0]         mag_c,
    output logic                neg_s,
    output logic                neg_c,
    output logic [9:0]          radius
);

    localparam int QTR = 2 ** (ANGLE_BITS - 2);
    localparam int AW  = ANGLE_BITS - 1;

    typedef logic [16:0] rom_t [QTR + 1];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= QTR; k++)
        begin
            r[k] = ppu_pkg::sine_entry(k, ANGLE_BITS - 2);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    ppu_pkg::ctl_t         ctl1_reg;
    ppu_pkg::ctl_t         ctl2_reg;
    logic [ANGLE_BITS-1:0] idx1_reg;
    logic [9:0]            r1_reg;
    logic [9:0]            r2_reg;
    logic [16:0]           mag_s_reg;
    logic [16:0]           mag_c_reg;
    logic                  neg_s_reg;
    logic                  neg_c_reg;

    logic [43:0]           phase_prod;
    logic [9:0]            r_next;
    logic                  pano_bad;
    logic [ANGLE_BITS-1:0] idx_c;
    logic [AW-1:0]         addr_s;
    logic [AW-1:0]         addr_c;

    // Stage 1: phase and radius
    assign phase_prod = col * phase_step;
    assign r_next     = 10'(row) + 10'(inner_radius);
    assign pano_bad   = (col >= pano_width) || (r_next >= outer_radius);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= '{valid: ctl_in.valid, sample: ctl_in.sample, bad: pano_bad};
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx1_reg <= phase_prod[31:32-ANGLE_BITS];
            r1_reg   <= r_next;
        end
    end

    // Stage 2: fold into the first quadrant and read the table
    assign idx_c  = idx1_reg + ANGLE_BITS'(QTR);
    assign addr_s = idx1_reg[ANGLE_BITS-2] ? (AW'(QTR) - AW'(idx1_reg[ANGLE_BITS-3:0]))
                                           : AW'(idx1_reg[ANGLE_BITS-3:0]);
    assign addr_c = idx_c[ANGLE_BITS-2] ? (AW'(QTR) - AW'(idx_c[ANGLE_BITS-3:0]))
                                        : AW'(idx_c[ANGLE_BITS-3:0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_s_reg <= SINE_ROM[addr_s];
            mag_c_reg <= SINE_ROM[addr_c];
            neg_s_reg <= idx1_reg[ANGLE_BITS-1];
            neg_c_reg <= idx_c[ANGLE_BITS-1];
            r2_reg    <= r1_reg;
        end
    end

    assign ctl_out = ctl2_reg;
    assign mag_s   = mag_s_reg;
    assign mag_c   = mag_c_reg;
    assign neg_s   = neg_s_reg;
    assign neg_c   = neg_c_reg;
    assign radius  = r2_reg;

endmodule

// ----- rtl/core/ppu_locate.sv -----
// Source point, neighbour clamping and fractions.
`timescale 1ns / 1ps

module ppu_locate #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ppu_pkg::ctl_t                 ctl_in,
    input  logic [16:0]                   mag_s,
    input  logic [16:0]                   mag_c,
    input  logic                          neg_s,
    input  logic                          neg_c,
    input  logic [9:0]                    radius,
    input  logic [9:0]                    center_x,
    input  logic [9:0]                    center_y,
    input  logic [15:0]                   lim_w,
    input  logic [15:0]                   lim_h,
    output ppu_pkg::ctl_t                 ctl_out,
    output logic [$clog2(MAX_WIDTH)-1:0]  x0,
    output logic [$clog2(MAX_WIDTH)-1:0]  x1,
    output logic [$clog2(MAX_HEIGHT)-1:0] y0,
    output logic [$clog2(MAX_HEIGHT)-1:0] y1,
    output logic [15:0]                   fx,
    output logic [15:0]                   fy
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    ppu_pkg::ctl_t      ctl3_reg;
    ppu_pkg::ctl_t      ctl4_reg;
    logic signed [28:0] prod_x_reg;
    logic signed [28:0] prod_y_reg;
    logic [9:0]         cx_reg;
    logic [9:0]         cy_reg;
    logic [XW-1:0]      x0_reg;
    logic [XW-1:0]      x1_reg;
    logic [YW-1:0]      y0_reg;
    logic [YW-1:0]      y1_reg;
    logic [15:0]        fx_reg;
    logic [15:0]        fy_reg;

    logic signed [17:0] s_val;
    logic signed [17:0] c_val;
    logic signed [30:0] qx;
    logic signed [30:0] qy;
    logic signed [15:0] ipx;
    logic signed [15:0] ipy;
    logic               img_bad;

    // Stage 3: radius times sine and cosine
    assign s_val = neg_s ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    assign c_val = neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_x_reg <= $signed({1'b0, radius}) * s_val;
            prod_y_reg <= $signed({1'b0, radius}) * c_val;
            cx_reg     <= center_x;
            cy_reg     <= center_y;
        end
    end

    // Stage 4: add the centre, floor, clamp
    assign qx  = $signed({5'd0, cx_reg, 16'd0}) + $signed({{2{prod_x_reg[28]}}, prod_x_reg});
    assign qy  = $signed({5'd0, cy_reg, 16'd0}) + $signed({{2{prod_y_reg[28]}}, prod_y_reg});
    assign ipx = $signed({qx[30], qx[30:16]});
    assign ipy = $signed({qy[30], qy[30:16]});
    assign img_bad = ppu_pkg::out_of(ipx, lim_w) || ppu_pkg::out_of(ipy, lim_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            ctl3_reg <= ctl_in;
            ctl4_reg <= '{valid: ctl3_reg.valid, sample: ctl3_reg.sample,
                          bad: ctl3_reg.bad | img_bad};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= XW'(ppu_pkg::clamp_idx(ipx, lim_w));
            x1_reg <= XW'(ppu_pkg::clamp_idx(ipx + 16'sd1, lim_w));
            y0_reg <= YW'(ppu_pkg::clamp_idx(ipy, lim_h));
            y1_reg <= YW'(ppu_pkg::clamp_idx(ipy + 16'sd1, lim_h));
            fx_reg <= qx[15:0];
            fy_reg <= qy[15:0];
        end
    end

    assign ctl_out = ctl4_reg;
    assign x0      = x0_reg;
    assign x1      = x1_reg;
    assign y0      = y0_reg;
    assign y1      = y1_reg;
    assign fx      = fx_reg;
    assign fy      = fy_reg;

endmodule

// ----- rtl/core/ppu_frame.sv -----
// Frame memory in four banks split by row and column parity.
`timescale 1ns / 1ps

module ppu_frame #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ppu_pkg::ctl_t                 ctl_in,
    input  ppu_pkg::wr_t                  wr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  x0,
    input  logic [$clog2(MAX_WIDTH)-1:0]  x1,
    input  logic [$clog2(MAX_HEIGHT)-1:0] y0,
    input  logic [$clog2(MAX_HEIGHT)-1:0] y1,
    input  logic [15:0]                   fx,
    input  logic [15:0]                   fy,
    output ppu_pkg::ctl_t                 ctl_out,
    output logic [3:0][23:0]              bank_q,
    output logic                          x0_odd,
    output logic                          y0_odd,
    output logic                          x_same,
    output logic                          y_same,
    output logic [15:0]                   fx_out,
    output logic [15:0]                   fy_out,
    output logic [9:0]                    src_x,
    output logic [9:0]                    src_y
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int DEPTH  = HALF_W * HALF_H;
    localparam int AW     = $clog2(DEPTH);

    ppu_pkg::ctl_t ctl5_reg;
    logic          x0_odd_reg;
    logic          y0_odd_reg;
    logic          x_same_reg;
    logic          y_same_reg;
    logic [15:0]   fx_reg;
    logic [15:0]   fy_reg;
    logic [9:0]    src_x_reg;
    logic [9:0]    src_y_reg;

    logic          wr_en;
    logic [XW-1:0] wx;
    logic [YW-1:0] wy;
    logic [AW-1:0] waddr;
    logic [1:0]    wbank;

    // Drop writes outside the frame.
    assign wr_en = adv && ctl_in.valid && (ctl_in.sample == ppu_pkg::CMD_WRITE)
                   && (32'(wr.x) < MAX_WIDTH) && (32'(wr.y) < MAX_HEIGHT);
    assign wx    = XW'(wr.x);
    assign wy    = YW'(wr.y);
    assign waddr = AW'(32'(wy >> 1) * HALF_W + 32'(wx >> 1));
    assign wbank = {wy[0], wx[0]};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [23:0]   mem [DEPTH];
        logic [23:0]   q_reg;
        logic [XW-1:0] xs;
        logic [YW-1:0] ys;
        logic [AW-1:0] raddr;

        // Pick the neighbour whose parity lands in this bank.
        assign xs    = (x0[0] == 1'(b)) ? x0 : x1;
        assign ys    = (y0[0] == 1'(b >> 1)) ? y0 : y1;
        assign raddr = AW'(32'(ys >> 1) * HALF_W + 32'(xs >> 1));

        always_ff @(posedge clk)
        begin
            if (wr_en && (wbank == 2'(b)))
                mem[waddr] <= wr.rgb;
            if (adv)
                q_reg <= mem[raddr];
        end

        assign bank_q[b] = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl5_reg <= '0;
        else if (adv)
            ctl5_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_odd_reg <= x0[0];
            y0_odd_reg <= y0[0];
            x_same_reg <= (x0 == x1);
            y_same_reg <= (y0 == y1);
            fx_reg     <= fx;
            fy_reg     <= fy;
            src_x_reg  <= 10'(x0);
            src_y_reg  <= 10'(y0);
        end
    end

    assign ctl_out = ctl5_reg;
    assign x0_odd  = x0_odd_reg;
    assign y0_odd  = y0_odd_reg;
    assign x_same  = x_same_reg;
    assign y_same  = y_same_reg;
    assign fx_out  = fx_reg;
    assign fy_out  = fy_reg;
    assign src_x   = src_x_reg;
    assign src_y   = src_y_reg;

endmodule

// ----- rtl/core/ppu_blend.sv -----
// Bilinear blend of the four neighbours, horizontal then vertical.
`timescale 1ns / 1ps

module ppu_blend (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  ppu_pkg::ctl_t    ctl_in,
    input  logic [3:0][23:0] bank_q,
    input  logic             x0_odd,
    input  logic             y0_odd,
    input  logic             x_same,
    input  logic             y_same,
    input  logic [15:0]      fx,
    input  logic [15:0]      fy,
    input  logic [9:0]       src_x_in,
    input  logic [9:0]       src_y_in,
    output ppu_pkg::ctl_t    ctl_out,
    output logic [2:0][7:0]  color,
    output logic [9:0]       src_x,
    output logic [9:0]       src_y
);

    ppu_pkg::ctl_t   ctl6_reg;
    logic [23:0]     top_reg [3];
    logic [23:0]     bot_reg [3];
    logic [16:0]     gy_reg;
    logic [15:0]     fy_reg;
    logic [9:0]      src_x_reg;
    logic [9:0]      src_y_reg;

    logic            x1_odd;
    logic            y1_odd;
    logic [23:0]     p00;
    logic [23:0]     p10;
    logic [23:0]     p01;
    logic [23:0]     p11;
    logic [16:0]     gx;
    logic [24:0]     top_sum [3];
    logic [24:0]     bot_sum [3];
    logic [40:0]     m_top [3];
    logic [40:0]     m_bot [3];
    logic [41:0]     acc [3];

    // Clamped edges reuse the same pixel for both neighbours.
    assign x1_odd = x_same ? x0_odd : ~x0_odd;
    assign y1_odd = y_same ? y0_odd : ~y0_odd;
    assign p00    = bank_q[{y0_odd, x0_odd}];
    assign p10    = bank_q[{y0_odd, x1_odd}];
    assign p01    = bank_q[{y1_odd, x0_odd}];
    assign p11    = bank_q[{y1_odd, x1_odd}];
    assign gx     = 17'h10000 - {1'b0, fx};

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        localparam int SH = 16 - 8 * c;
        assign top_sum[c] = p00[SH +: 8] * gx + p10[SH +: 8] * fx;
        assign bot_sum[c] = p01[SH +: 8] * gx + p11[SH +: 8] * fx;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                top_reg[c] <= 24'(top_sum[c]);
                bot_reg[c] <= 24'(bot_sum[c]);
            end
        end

        assign m_top[c] = top_reg[c] * gy_reg;
        assign m_bot[c] = bot_reg[c] * fy_reg;
        assign acc[c]   = 42'(m_top[c]) + 42'(m_bot[c]) + (42'd1 << 31);
        assign color[c] = (acc[c][41:32] > 10'd255) ? 8'd255 : acc[c][39:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl6_reg <= '0;
        else if (adv)
            ctl6_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gy_reg    <= 17'h10000 - {1'b0, fy};
            fy_reg    <= fy;
            src_x_reg <= src_x_in;
            src_y_reg <= src_y_in;
        end
    end

    assign ctl_out = ctl6_reg;
    assign src_x   = src_x_reg;
    assign src_y   = src_y_reg;

endmodule

// ----- rtl/core/polar_panorama_unwarp.sv -----
// Top level of the polar panorama unwarp: config, pipeline control, output register.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_write_en          cfg_index, cfg_data
//  in       in         in_valid / in_stall   command, pixel_x/y, red/green/blue, pano_col/row
//  out      out        out_valid / out_stall out_red/green/blue, source_x/y, status
//
// One request per clock while the pipeline is not held. A taken sample passes the input, phase,
// table, multiply, locate, memory and blend registers before it shows on out_valid.
// A write takes its memory slot at the same stage as sample reads, so order is kept.
// The whole pipeline holds only when a result waits and out_stall is high.
// Reset clears valid bits and loads the config defaults; the frame memory stays undefined until written.
`timescale 1ns / 1ps
`include "polar_panorama_unwarp_defines.svh"

module polar_panorama_unwarp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ANGLE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [11:0] pano_col,
    input  logic [8:0]  pano_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [9:0]  source_x,
    output logic [9:0]  source_y,
    output logic        status
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [9:0]  center_x_reg;
    logic [9:0]  center_y_reg;
    logic [8:0]  inner_radius_reg;
    logic [9:0]  outer_radius_reg;
    logic [11:0] pano_width_reg;
    logic [31:0] phase_step_reg;

    ppu_pkg::ctl_t ctl0_reg;
    logic [11:0]   col0_reg;
    logic [8:0]    row0_reg;
    ppu_pkg::wr_t  wr_reg [5];

    logic        out_valid_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic [9:0]  source_x_reg;
    logic [9:0]  source_y_reg;
    logic        status_reg;

    logic          adv;
    logic          take;
    logic          load_out;
    logic [15:0]   lim_w;
    logic [15:0]   lim_h;

    ppu_pkg::ctl_t ctl2;
    ppu_pkg::ctl_t ctl4;
    ppu_pkg::ctl_t ctl5;
    ppu_pkg::ctl_t ctl6;
    logic [16:0]   mag_s;
    logic [16:0]   mag_c;
    logic          neg_s;
    logic          neg_c;
    logic [9:0]    radius;
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y0;
    logic [YW-1:0] y1;
    logic [15:0]   fx4;
    logic [15:0]   fy4;
    logic [3:0][23:0] bank_q;
    logic          x0_odd;
    logic          y0_odd;
    logic          x_same;
    logic          y_same;
    logic [15:0]   fx5;
    logic [15:0]   fy5;
    logic [9:0]    sx5;
    logic [9:0]    sy5;
    logic [2:0][7:0] color;
    logic [9:0]    sx6;
    logic [9:0]    sy6;

    // Hold the pipeline only when the last stage has a sample and the output is blocked.
    assign load_out = ctl6.valid && (ctl6.sample == ppu_pkg::CMD_SAMPLE);
    assign adv      = !(out_valid_reg && out_stall && load_out);
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 11'd1024;
            center_x_reg     <= 10'd512;
            center_y_reg     <= 10'd512;
            inner_radius_reg <= 9'd0;
            outer_radius_reg <= 10'd512;
            pano_width_reg   <= 12'd3216;
            phase_step_reg   <= 32'd1335499;
        end
        else if (cfg_write_en)
        begin
            unique case (ppu_pkg::cfg_reg_t'(cfg_index))
                ppu_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                ppu_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[10:0];
                ppu_pkg::CFG_CENTER_X:     center_x_reg     <= cfg_data[9:0];
                ppu_pkg::CFG_CENTER_Y:     center_y_reg     <= cfg_data[9:0];
                ppu_pkg::CFG_INNER_RADIUS: inner_radius_reg <= cfg_data[8:0];
                ppu_pkg::CFG_OUTER_RADIUS: outer_radius_reg <= cfg_data[9:0];
                ppu_pkg::CFG_PANO_WIDTH:   pano_width_reg   <= cfg_data[11:0];
                ppu_pkg::CFG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                default:                   phase_step_reg   <= phase_step_reg;
            endcase
        end
    end

    // Effective image size, clamped to 1 .. max.
    always_comb
    begin
        if (image_width_reg == '0)
            lim_w = 16'd1;
        else if (16'(image_width_reg) > 16'(MAX_WIDTH))
            lim_w = 16'(MAX_WIDTH);
        else
            lim_w = 16'(image_width_reg);
        if (image_height_reg == '0)
            lim_h = 16'd1;
        else if (16'(image_height_reg) > 16'(MAX_HEIGHT))
            lim_h = 16'(MAX_HEIGHT);
        else
            lim_h = 16'(image_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (adv)
            ctl0_reg <= '{valid: take, sample: command, bad: 1'b0};
    end

    // Write payload rides alongside the pipeline up to the memory stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col0_reg  <= pano_col;
            row0_reg  <= pano_row;
            wr_reg[0] <= '{x: pixel_x, y: pixel_y, rgb: {red, green, blue}};
            for (int i = 1; i < 5; i++)
            begin
                wr_reg[i] <= wr_reg[i - 1];
            end
        end
    end

    ppu_angle #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .ctl_in       (ctl0_reg),
        .col          (col0_reg),
        .row          (row0_reg),
        .inner_radius (inner_radius_reg),
        .outer_radius (outer_radius_reg),
        .pano_width   (pano_width_reg),
        .phase_step   (phase_step_reg),
        .ctl_out      (ctl2),
        .mag_s        (mag_s),
        .mag_c        (mag_c),
        .neg_s        (neg_s),
        .neg_c        (neg_c),
        .radius       (radius)
    );

    ppu_locate #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_locate (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (ctl2),
        .mag_s    (mag_s),
        .mag_c    (mag_c),
        .neg_s    (neg_s),
        .neg_c    (neg_c),
        .radius   (radius),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .lim_w    (lim_w),
        .lim_h    (lim_h),
        .ctl_out  (ctl4),
        .x0       (x0),
        .x1       (x1),
        .y0       (y0),
        .y1       (y1),
        .fx       (fx4),
        .fy       (fy4)
    );

    ppu_frame #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (ctl4),
        .wr      (wr_reg[4]),
        .x0      (x0),
        .x1      (x1),
        .y0      (y0),
        .y1      (y1),
        .fx      (fx4),
        .fy      (fy4),
        .ctl_out (ctl5),
        .bank_q  (bank_q),
        .x0_odd  (x0_odd),
        .y0_odd  (y0_odd),
        .x_same  (x_same),
        .y_same  (y_same),
        .fx_out  (fx5),
        .fy_out  (fy5),
        .src_x   (sx5),
        .src_y   (sy5)
    );

    ppu_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (ctl5),
        .bank_q   (bank_q),
        .x0_odd   (x0_odd),
        .y0_odd   (y0_odd),
        .x_same   (x_same),
        .y_same   (y_same),
        .fx       (fx5),
        .fy       (fy5),
        .src_x_in (sx5),
        .src_y_in (sy5),
        .ctl_out  (ctl6),
        .color    (color),
        .src_x    (sx6),
        .src_y    (sy6)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && load_out)
        begin
            out_red_reg   <= color[0];
            out_green_reg <= color[1];
            out_blue_reg  <= color[2];
            source_x_reg  <= sx6;
            source_y_reg  <= sy6;
            status_reg    <= ctl6.bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign source_x  = source_x_reg;
    assign source_y  = source_y_reg;
    assign status    = status_reg;

    `PPU_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall && load_out))
    `PPU_ASSERT_NEXT(a_out_load, adv && load_out, out_valid)
    `PPU_ASSERT_NEXT(a_write_silent, !out_valid && !load_out, !out_valid)

endmodule
